[rtl/core/ssrc_pkg.sv]
// Shared constants, types and register codes of the sinc sample rate converter.
// No dependencies; the channel interfaces, ssrc_mac and the top level import this package.
package ssrc_pkg;

   localparam int TAPS_DEF      = 16;
   localparam int TABLE_RES_DEF = 256;
   localparam int COEF_FRAC_DEF = 12;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 16;
   localparam int INDEX_W   = 11;
   localparam int RATE_W    = 24;
   localparam int FRAC_W    = 16;
   localparam int ACC_W     = 25;
   localparam int PROD_W    = 32;
   localparam int PTR_MAX_W = 6;

   localparam int OUT_LIMIT = 64;
   localparam int CNT_W     = $clog2(OUT_LIMIT + 1);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic              BYPASS_RST   = 1'b1;
   localparam logic [RATE_W-1:0] IN_RATE_RST  = 24'd223722;
   localparam logic [RATE_W-1:0] OUT_RATE_RST = 24'd44100;
   localparam logic [FRAC_W-1:0] RATIO_RST    = 16'd0;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BYPASS     = 2'd0,
      CSR_IN_RATE    = 2'd1,
      CSR_OUT_RATE   = 2'd2,
      CSR_RATIO_FRAC = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic                 start;
      logic [FRAC_W-1:0]    phase;
      logic [PTR_MAX_W-1:0] base;
   } mac_ctl_type;

endpackage

[rtl/core/ssrc_req_if.sv]
// Input channel of the converter: valid/ready with sample or coefficient payload.
// Depends on ssrc_pkg.
interface ssrc_req_if;
   import ssrc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic signed [SAMPLE_W-1:0] sample;
   logic [INDEX_W-1:0]         coef_index;
   logic signed [COEF_W-1:0]   coef_value;

   modport source (output valid, kind, sample, coef_index, coef_value, input ready);
   modport sink   (input valid, kind, sample, coef_index, coef_value, output ready);
endinterface

[rtl/core/ssrc_rsp_if.sv]
// Result channel of the converter: valid/ready with one output sample per transfer.
// Depends on ssrc_pkg.
interface ssrc_rsp_if;
   import ssrc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] out_sample;
   logic                       last;

   modport source (output valid, out_sample, last, input ready);
   modport sink   (input valid, out_sample, last, output ready);
endinterface

[rtl/core/ssrc_csr_if.sv]
// Register write channel of the converter: valid/ready with index and data.
// Depends on ssrc_pkg.
interface ssrc_csr_if;
   import ssrc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/ssrc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssrc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ssrc_mac.sv]
// Tap sequencer and multiply-accumulate pipeline for one interpolated output.
// Depends on ssrc_pkg; reads the coefficient and window RAMs owned by the top level.
module ssrc_mac #(
   parameter int TAPS             = ssrc_pkg::TAPS_DEF,
   parameter int TABLE_RESOLUTION = ssrc_pkg::TABLE_RES_DEF,
   parameter int COEF_FRAC_BITS   = ssrc_pkg::COEF_FRAC_DEF,
   localparam int TAP_W  = $clog2(TAPS),
   localparam int TBL_AW = $clog2(TABLE_RESOLUTION * TAPS / 2)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  ssrc_pkg::mac_ctl_type              ctl,
   input  logic [TAPS-1:0]                    win_vld,
   output logic                               tbl_rd_en,
   output logic [TBL_AW-1:0]                  tbl_rd_addr,
   input  logic [ssrc_pkg::COEF_W-1:0]        tbl_rd_data,
   output logic                               win_rd_en,
   output logic [TAP_W-1:0]                   win_rd_addr,
   input  logic [ssrc_pkg::SAMPLE_W-1:0]      win_rd_data,
   output logic                               done,
   output logic signed [ssrc_pkg::SAMPLE_W-1:0] result
);
   import ssrc_pkg::*;

   localparam int TBL_SIZE = TABLE_RESOLUTION * TAPS / 2;
   localparam int CENTER   = TAPS / 2 - 1;
   localparam int KC_W     = $clog2(TAPS + 1);
   localparam int OFS_W    = $clog2(TAPS / 2 + 1);
   localparam int DIST_W   = OFS_W + FRAC_W;
   localparam int RES_W    = $clog2(TABLE_RESOLUTION + 1);
   localparam int SC_W     = DIST_W + RES_W;
   localparam int MAG_W    = SC_W - FRAC_W;

   logic                 run_ff;
   logic [KC_W-1:0]      k_ff;
   logic [FRAC_W-1:0]    phase_ff;
   logic [TAP_W-1:0]     base_ff;

   logic [TAP_W-1:0]     tap;
   logic                 tail0;
   logic [TAP_W:0]       ofs_full;
   logic [DIST_W-1:0]    span;
   logic [SC_W-1:0]      scaled_in;
   logic [TAP_W:0]       wsum;
   logic [TAP_W-1:0]     waddr_in;

   logic                 v1_ff, tail1_ff;
   logic [SC_W-1:0]      scaled_ff;
   logic [TAP_W-1:0]     waddr_ff;
   logic [MAG_W-1:0]     mag;

   logic                 v2_ff, tail2_ff, wv2_ff;
   logic signed [SAMPLE_W-1:0] win_s;
   logic signed [COEF_W-1:0]   coef_s;
   logic signed [PROD_W-1:0]   prod_in;

   logic                 v3_ff, tail3_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic [PROD_W-1:0]    sum_ff;
   logic                 done_ff;

   assign tap   = k_ff[TAP_W-1:0];
   assign tail0 = (k_ff == KC_W'(TAPS - 1));

   always_comb begin
      if ({1'b0, tap} <= (TAP_W+1)'(CENTER)) begin
         ofs_full = (TAP_W+1)'(CENTER) - {1'b0, tap};
         span     = {ofs_full[OFS_W-1:0], {FRAC_W{1'b0}}} + {{OFS_W{1'b0}}, phase_ff};
      end else begin
         ofs_full = {1'b0, tap} - (TAP_W+1)'(CENTER);
         span     = {ofs_full[OFS_W-1:0], {FRAC_W{1'b0}}} - {{OFS_W{1'b0}}, phase_ff};
      end
      scaled_in = SC_W'(span) * SC_W'(TABLE_RESOLUTION);
      wsum      = {1'b0, base_ff} + {1'b0, tap};
      waddr_in  = (wsum >= (TAP_W+1)'(TAPS)) ? TAP_W'(wsum - (TAP_W+1)'(TAPS))
                                             : wsum[TAP_W-1:0];
   end

   assign mag         = scaled_ff[SC_W-1:FRAC_W];
   assign tbl_rd_en   = v1_ff;
   assign tbl_rd_addr = (mag > MAG_W'(TBL_SIZE - 1)) ? TBL_AW'(TBL_SIZE - 1)
                                                      : mag[TBL_AW-1:0];
   assign win_rd_en   = v1_ff;
   assign win_rd_addr = waddr_ff;

   assign win_s   = wv2_ff ? $signed(win_rd_data) : '0;
   assign coef_s  = $signed(tbl_rd_data);
   assign prod_in = win_s * coef_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         k_ff     <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         if (ctl.start) begin
            run_ff <= 1'b1;
            k_ff   <= '0;
         end else if (run_ff) begin
            run_ff <= !tail0;
            k_ff   <= k_ff + 1'b1;
         end
         v1_ff   <= run_ff;
         v2_ff   <= v1_ff;
         v3_ff   <= v2_ff;
         done_ff <= v3_ff && tail3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         phase_ff <= ctl.phase;
         base_ff  <= ctl.base[TAP_W-1:0];
         sum_ff   <= '0;
      end else if (v3_ff) begin
         sum_ff <= sum_ff + prod_ff;
      end
      tail1_ff  <= tail0;
      scaled_ff <= scaled_in;
      waddr_ff  <= waddr_in;
      tail2_ff  <= tail1_ff;
      wv2_ff    <= win_vld[waddr_ff];
      tail3_ff  <= tail2_ff;
      prod_ff   <= prod_in;
   end

   assign done   = done_ff;
   assign result = $signed(sum_ff[COEF_FRAC_BITS+SAMPLE_W-1:COEF_FRAC_BITS]);

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !run_ff && !v1_ff && !v2_ff && !v3_ff)
      else $error("tap sequence restarted while busy");
   a_done_after_tail: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(v3_ff) && $past(tail3_ff))
      else $error("done without a final tap");
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> k_ff < KC_W'(TAPS))
      else $error("tap counter beyond tap count");

endmodule

[rtl/core/sinc_sample_rate_converter_core.sv]
// Top level of the windowed-sinc sample rate converter: registers, control, RAMs.
// Depends on ssrc_pkg, the three channel interfaces, ssrc_ram and ssrc_mac.
//
// One item is taken at a time. A sample in interpolating mode walks the taps
// once per output it produces, up to 64 outputs, and produces none when no
// output is owed; each output also waits while the result register still
// holds an output not yet taken. The taps are walked by the single
// multiply-accumulate through the read port of the coefficient RAM, one tap
// per cycle. The window lives in a TAPS-entry RAM with per-entry valid bits,
// so it reads as zero after reset without a clearing pass; coefficient
// entries must be written before use. Register writes are taken whenever
// out of reset and should be made only while idle.
module sinc_sample_rate_converter_core #(
   parameter int TAPS             = ssrc_pkg::TAPS_DEF,
   parameter int TABLE_RESOLUTION = ssrc_pkg::TABLE_RES_DEF,
   parameter int COEF_FRAC_BITS   = ssrc_pkg::COEF_FRAC_DEF
) (
   input logic         clock,
   input logic         reset,
   ssrc_req_if.sink    req_bus,
   ssrc_rsp_if.source  rsp_bus,
   ssrc_csr_if.sink    csr_bus
);
   import ssrc_pkg::*;

   localparam int TAP_W    = $clog2(TAPS);
   localparam int TBL_SIZE = TABLE_RESOLUTION * TAPS / 2;
   localparam int TBL_AW   = $clog2(TBL_SIZE);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_RUN   = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic                    bypass_ff;
   logic [RATE_W-1:0]       in_rate_ff, out_rate_ff;
   logic [FRAC_W-1:0]       ratio_ff;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic [FRAC_W-1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [TAP_W-1:0]        win_ptr_ff, win_ptr_in;
   logic [TAPS-1:0]         win_vld_ff, win_vld_in;
   logic [SAMPLE_W-1:0]     res_sample_ff, res_sample_in;
   logic                    res_last_ff, res_last_in;
   logic                    out_valid_ff, out_valid_in;
   logic [SAMPLE_W-1:0]     out_sample_ff;
   logic                    out_last_ff;

   logic                    req_take;
   logic                    out_load;
   logic [ACC_W:0]          acc_sum;
   logic [ACC_W-1:0]        acc_sat;
   logic                    rate_due;
   logic                    check_go;
   logic                    more;
   logic                    tbl_we;
   logic                    win_we;
   mac_ctl_type             mac_ctl;
   logic                    mac_done;
   logic signed [SAMPLE_W-1:0] mac_result;
   logic                    tbl_rd_en, win_rd_en;
   logic [TBL_AW-1:0]       tbl_rd_addr;
   logic [TAP_W-1:0]        win_rd_addr;
   logic [COEF_W-1:0]       tbl_rd_data;
   logic [SAMPLE_W-1:0]     win_rd_data;

   assign req_bus.ready = (state_ff == ST_IDLE) && !reset;
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = !reset;

   assign out_load = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_bus.ready);

   assign acc_sum  = {1'b0, acc_ff} + (ACC_W+1)'(out_rate_ff);
   assign acc_sat  = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
   assign rate_due = (acc_ff >= ACC_W'(in_rate_ff));
   assign check_go = (cnt_ff < CNT_W'(OUT_LIMIT)) && rate_due;
   assign more     = (cnt_ff != CNT_W'(OUT_LIMIT)) && rate_due;

   assign tbl_we = req_take && (req_bus.kind == KIND_COEF)
                   && ({21'd0, req_bus.coef_index} < 32'(TBL_SIZE));
   assign win_we = req_take && (req_bus.kind == KIND_SAMPLE) && !bypass_ff;

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      win_ptr_in    = win_ptr_ff;
      win_vld_in    = win_vld_ff;
      res_sample_in = res_sample_ff;
      res_last_in   = res_last_ff;
      mac_ctl.start = 1'b0;
      mac_ctl.phase = phase_ff;
      mac_ctl.base  = PTR_MAX_W'(win_ptr_ff);
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req_bus.kind == KIND_SAMPLE) begin
               if (bypass_ff) begin
                  res_sample_in = req_bus.sample;
                  res_last_in   = 1'b1;
                  state_in      = ST_EMIT;
               end else begin
                  acc_in                 = acc_sat;
                  cnt_in                 = '0;
                  win_vld_in[win_ptr_ff] = 1'b1;
                  win_ptr_in = (win_ptr_ff == TAP_W'(TAPS - 1)) ? '0 : win_ptr_ff + 1'b1;
                  state_in   = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (check_go) begin
               acc_in        = acc_ff - ACC_W'(in_rate_ff);
               phase_in      = phase_ff + ratio_ff;
               cnt_in        = cnt_ff + 1'b1;
               mac_ctl.start = 1'b1;
               mac_ctl.phase = phase_in;
               state_in      = ST_RUN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RUN: begin
            if (mac_done) begin
               res_sample_in = mac_result;
               res_last_in   = !more;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               state_in = res_last_ff ? ST_IDLE : ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         win_ptr_ff   <= '0;
         win_vld_ff   <= '0;
         out_valid_ff <= 1'b0;
         bypass_ff    <= BYPASS_RST;
         in_rate_ff   <= IN_RATE_RST;
         out_rate_ff  <= OUT_RATE_RST;
         ratio_ff     <= RATIO_RST;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         win_ptr_ff   <= win_ptr_in;
         win_vld_ff   <= win_vld_in;
         out_valid_ff <= out_valid_in;
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_idx_type'(csr_bus.index))
               CSR_BYPASS:     bypass_ff   <= csr_bus.data[0];
               CSR_IN_RATE:    in_rate_ff  <= csr_bus.data[RATE_W-1:0];
               CSR_OUT_RATE:   out_rate_ff <= csr_bus.data[RATE_W-1:0];
               CSR_RATIO_FRAC: ratio_ff    <= csr_bus.data[FRAC_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      res_sample_ff <= res_sample_in;
      res_last_ff   <= res_last_in;
      if (out_load) begin
         out_sample_ff <= res_sample_ff;
         out_last_ff   <= res_last_ff;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.out_sample = $signed(out_sample_ff);
   assign rsp_bus.last       = out_last_ff;

   ssrc_ram #(
      .WIDTH (COEF_W),
      .DEPTH (TBL_SIZE)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (TBL_AW'(req_bus.coef_index)),
      .wr_data (req_bus.coef_value),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   ssrc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (TAPS)
   ) u_win_ram (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (win_ptr_ff),
      .wr_data (req_bus.sample),
      .rd_en   (win_rd_en),
      .rd_addr (win_rd_addr),
      .rd_data (win_rd_data)
   );

   ssrc_mac #(
      .TAPS             (TAPS),
      .TABLE_RESOLUTION (TABLE_RESOLUTION),
      .COEF_FRAC_BITS   (COEF_FRAC_BITS)
   ) u_mac (
      .clock       (clock),
      .reset       (reset),
      .ctl         (mac_ctl),
      .win_vld     (win_vld_ff),
      .tbl_rd_en   (tbl_rd_en),
      .tbl_rd_addr (tbl_rd_addr),
      .tbl_rd_data (tbl_rd_data),
      .win_rd_en   (win_rd_en),
      .win_rd_addr (win_rd_addr),
      .win_rd_data (win_rd_data),
      .done        (mac_done),
      .result      (mac_result)
   );

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(OUT_LIMIT))
      else $error("output count beyond limit");
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == ST_RUN)
      else $error("interpolation result outside run state");
   a_done_counted: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> cnt_ff != '0)
      else $error("interpolation result with no output owed");
   a_not_last_continues: assert property (@(posedge clock) disable iff (reset)
      (out_load && !res_last_ff) |=> state_ff == ST_CHECK)
      else $error("non-final output not followed by a rate check");

endmodule
